// ----- rtl/ffsm_pkg.sv -----
package ffsm_pkg;

  localparam int SAMPLES_PER_SYMBOL = 32;
  localparam int MAX_PAYLOAD        = 16;

  localparam int SMP_W  = 12;
  localparam int IDX_W  = $clog2(SAMPLES_PER_SYMBOL);
  localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int PL_W   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int FP_W   = $clog2(12 + 4 * MAX_PAYLOAD);

  localparam logic [SMP_W-1:0] MIDSCALE = 12'h800;

  typedef enum logic [1:0] {
    ACT_BUFFER = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_SEND   = 2'd2
  } action_e;

  // symbol codes: bit1 half amplitude, bit0 inverted phase
  localparam logic [1:0] SYM_IDLE_A = 2'd0;
  localparam logic [1:0] SYM_IDLE_B = 2'd3;
  localparam logic [1:0] SYNC_DIG_A = 2'd1;
  localparam logic [1:0] SYNC_DIG_B = 2'd2;

  // positive half period, full or half amplitude
  function automatic logic [10:0] half_wave(input logic half, input logic [3:0] j);
    logic [10:0] full_v;
    logic [10:0] half_v;
    case (j)
      4'd0:    begin full_v = 11'h000; half_v = 11'h000; end
      4'd1:    begin full_v = 11'h18F; half_v = 11'h0C8; end
      4'd2:    begin full_v = 11'h30F; half_v = 11'h187; end
      4'd3:    begin full_v = 11'h471; half_v = 11'h238; end
      4'd4:    begin full_v = 11'h5A7; half_v = 11'h2D3; end
      4'd5:    begin full_v = 11'h6A6; half_v = 11'h353; end
      4'd6:    begin full_v = 11'h763; half_v = 11'h3B1; end
      4'd7:    begin full_v = 11'h7D8; half_v = 11'h3EB; end
      4'd8:    begin full_v = 11'h7FF; half_v = 11'h3FF; end
      4'd9:    begin full_v = 11'h7D8; half_v = 11'h3EB; end
      4'd10:   begin full_v = 11'h763; half_v = 11'h3B1; end
      4'd11:   begin full_v = 11'h6A6; half_v = 11'h353; end
      4'd12:   begin full_v = 11'h5A7; half_v = 11'h2D3; end
      4'd13:   begin full_v = 11'h471; half_v = 11'h238; end
      4'd14:   begin full_v = 11'h30F; half_v = 11'h187; end
      default: begin full_v = 11'h18F; half_v = 11'h0C8; end
    endcase
    return half ? half_v : full_v;
  endfunction

  // 2-bit digit of a byte, least significant first
  function automatic logic [1:0] digit_of(input logic [7:0] b, input logic [1:0] sel);
    return b[2*sel +: 2];
  endfunction

endpackage

// ----- rtl/framed_four_symbol_modulator_top.sv -----
// Framed four-symbol modulator.
// Input stream (s_axis): tuser carries the action, tdata the payload byte.
//   action 0 asks for one symbol, 1 appends a payload byte, 2 requests a frame.
//   Writes and send requests are taken every cycle and give no output.
//   A symbol request is taken when the sample generator is free, or in the
//   same cycle as the final beat of the current symbol is taken.
// Output stream (m_axis): one DAC sample per beat, 32 beats per symbol,
//   tlast on the 32nd. tuser carries the symbol code and the frame flag.
// Latency: the first sample is valid the cycle after the request is taken.
// Symbol pacing is set by the sample counter that walks the sine table one
//   entry per output beat.
// While idle the symbols alternate 0,3; after an idle pair with a send
// pending the frame digits go out (sync 1,2, id, length, payload, checksum).
// Reset clears the frame sequencer, the payload count, the message id and
// the generator; stored payload bytes are not cleared.
// A stalled receiver holds the current sample; symbol requests wait, while
// writes and send requests are still taken.
module framed_four_symbol_modulator_top
  import ffsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] payload_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [11:0] dac_sample, [15:12] zero
  output logic        m_axis_tlast_o,   // last_sample
  output logic [2:0]  m_axis_tuser_o    // [1:0] symbol, [2] sending
);

  // frame sequencer state
  logic             frame_mode_q, frame_mode_d;
  logic             idle_pos_q, idle_pos_d;
  logic [FP_W-1:0]  frame_pos_q, frame_pos_d;
  logic             pending_q, pending_d;
  logic [7:0]       msg_id_q, msg_id_d;
  logic [CNT_W-1:0] pl_count_q, pl_count_d;
  logic [7:0]       checksum_q, checksum_d;
  logic [7:0]       pl_store [MAX_PAYLOAD];

  // sample generator
  logic             active_q, active_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       sym_q, sym_d;
  logic             sending_q, sending_d;

  logic             in_fire, out_fire, last_beat, gen_free, busy, wr_en;
  logic             is_buffer;
  logic [FP_W-1:0]  data_end;
  logic [FP_W:0]    pos_inc;
  logic [FP_W-3:0]  byte_k;
  logic [1:0]       digit;
  logic [1:0]       new_sym;
  logic             new_sending;
  logic [IDX_W-1:0] phase_idx;
  logic [10:0]      mag;

  assign last_beat = (idx_q == IDX_W'(SAMPLES_PER_SYMBOL - 1));
  assign out_fire  = m_axis_tvalid_o && m_axis_tready_i;
  assign gen_free  = !active_q || (out_fire && last_beat);
  assign is_buffer = (s_axis_tuser_i == ACT_BUFFER);
  assign s_axis_tready_o = !is_buffer || gen_free;
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign busy      = pending_q || frame_mode_q;
  assign wr_en     = in_fire && (s_axis_tuser_i == ACT_WRITE) && !busy &&
                     (pl_count_q < CNT_W'(MAX_PAYLOAD));

  // frame digit at the current position
  assign data_end = FP_W'(8) + FP_W'({pl_count_q, 2'b00});
  assign pos_inc  = {1'b0, frame_pos_q} + 1'b1;
  assign byte_k   = frame_pos_q[FP_W-1:2] - (FP_W-2)'(2);

  always_comb begin
    if (frame_pos_q == '0) begin
      digit = SYNC_DIG_A;
    end else if (frame_pos_q == FP_W'(1)) begin
      digit = SYNC_DIG_B;
    end else if (frame_pos_q < FP_W'(4)) begin
      // id digits sit at positions 2 and 3: low digit first
      digit = digit_of(msg_id_q, {1'b0, frame_pos_q[0]});
    end else if (frame_pos_q < FP_W'(8)) begin
      digit = digit_of(8'(pl_count_q), frame_pos_q[1:0]);
    end else if (frame_pos_q < data_end) begin
      digit = digit_of(pl_store[byte_k[PL_W-1:0]], frame_pos_q[1:0]);
    end else begin
      // data_end is a multiple of four
      digit = digit_of(checksum_q, frame_pos_q[1:0]);
    end
  end

  always_comb begin
    frame_mode_d = frame_mode_q;
    idle_pos_d   = idle_pos_q;
    frame_pos_d  = frame_pos_q;
    pending_d    = pending_q;
    msg_id_d     = msg_id_q;
    pl_count_d   = pl_count_q;
    checksum_d   = checksum_q;
    new_sym      = SYM_IDLE_A;
    new_sending  = 1'b0;
    if (in_fire) begin
      case (s_axis_tuser_i)
        ACT_WRITE: begin
          if (wr_en) begin
            pl_count_d = pl_count_q + 1'b1;
          end
        end
        ACT_SEND: begin
          if (!busy) begin
            msg_id_d  = msg_id_q + 8'd1;
            pending_d = 1'b1;
          end
        end
        ACT_BUFFER: begin
          if (frame_mode_q) begin
            new_sending = 1'b1;
            new_sym     = digit;
            if (frame_pos_q < data_end) begin
              checksum_d = checksum_q + 8'(digit);
            end
            if (pos_inc < ({1'b0, data_end} + (FP_W+1)'(4))) begin
              frame_pos_d = pos_inc[FP_W-1:0];
            end else begin
              frame_pos_d  = '0;
              frame_mode_d = 1'b0;
              pl_count_d   = '0;
            end
          end else begin
            new_sym = idle_pos_q ? SYM_IDLE_B : SYM_IDLE_A;
            if (!idle_pos_q) begin
              idle_pos_d = 1'b1;
            end else begin
              idle_pos_d = 1'b0;
              if (pending_q) begin
                pending_d    = 1'b0;
                frame_mode_d = 1'b1;
                frame_pos_d  = '0;
                checksum_d   = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // generator next state
  always_comb begin
    active_d  = active_q;
    idx_d     = idx_q;
    sym_d     = sym_q;
    sending_d = sending_q;
    if (out_fire) begin
      idx_d = idx_q + 1'b1;
      if (last_beat) begin
        active_d = 1'b0;
        idx_d    = '0;
      end
    end
    if (in_fire && is_buffer) begin
      active_d  = 1'b1;
      idx_d     = '0;
      sym_d     = new_sym;
      sending_d = new_sending;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_mode_q <= 1'b0;
      idle_pos_q   <= 1'b0;
      frame_pos_q  <= '0;
      pending_q    <= 1'b0;
      msg_id_q     <= '0;
      pl_count_q   <= '0;
      checksum_q   <= '0;
      active_q     <= 1'b0;
      idx_q        <= '0;
      sym_q        <= '0;
      sending_q    <= 1'b0;
    end else begin
      frame_mode_q <= frame_mode_d;
      idle_pos_q   <= idle_pos_d;
      frame_pos_q  <= frame_pos_d;
      pending_q    <= pending_d;
      msg_id_q     <= msg_id_d;
      pl_count_q   <= pl_count_d;
      checksum_q   <= checksum_d;
      active_q     <= active_d;
      idx_q        <= idx_d;
      sym_q        <= sym_d;
      sending_q    <= sending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pl_store[pl_count_q[PL_W-1:0]] <= s_axis_tdata_i;
    end
  end

  // inverted phase starts half a period in
  assign phase_idx = idx_q + (sym_q[0] ? IDX_W'(SAMPLES_PER_SYMBOL / 2) : '0);
  assign mag       = half_wave(sym_q[1], phase_idx[IDX_W-2:0]);

  assign m_axis_tvalid_o = active_q;
  assign m_axis_tdata_o  = {4'b0000, phase_idx[IDX_W-1] ? (MIDSCALE - SMP_W'(mag))
                                                        : (MIDSCALE + SMP_W'(mag))};
  assign m_axis_tlast_o  = last_beat;
  assign m_axis_tuser_o  = {sending_q, sym_q};

`ifndef SYNTHESIS
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (idx_q == '0))
    else $error("sample index moved while generator idle");

  a_mode_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_mode_q |-> !pending_q)
    else $error("send pending during frame");

  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame_mode_q |-> (frame_pos_q == '0))
    else $error("frame position nonzero outside frame");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pl_count_q <= CNT_W'(MAX_PAYLOAD))
    else $error("payload count beyond capacity");

  a_mid_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !last_beat) |=> (active_q && $stable(sym_q)))
    else $error("symbol cut short");
`endif

endmodule

// ----- verif/ffsm_sample_checker.sv -----
module ffsm_sample_checker
  import ffsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] payload_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] action
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // [11:0] dac_sample, [15:12] zero
  input  logic        m_axis_tlast_i,   // last_sample
  input  logic [2:0]  m_axis_tuser_i,   // [1:0] symbol, [2] sending
  output int          fail_count_o,
  output int          samples_due_o
);

  typedef struct packed {
    logic [11:0] level;
    logic        last;
    logic [1:0]  sym;
    logic        in_frame;
  } dac_beat_t;

  // positive half period of the sine, full and half amplitude
  localparam logic [10:0] FULL_ARC [16] = '{
    11'h000, 11'h18F, 11'h30F, 11'h471, 11'h5A7, 11'h6A6, 11'h763, 11'h7D8,
    11'h7FF, 11'h7D8, 11'h763, 11'h6A6, 11'h5A7, 11'h471, 11'h30F, 11'h18F
  };
  localparam logic [10:0] HALF_ARC [16] = '{
    11'h000, 11'h0C8, 11'h187, 11'h238, 11'h2D3, 11'h353, 11'h3B1, 11'h3EB,
    11'h3FF, 11'h3EB, 11'h3B1, 11'h353, 11'h2D3, 11'h238, 11'h187, 11'h0C8
  };

  dac_beat_t expected_beats[$];

  // frame sequencer copy
  logic             in_frame;
  logic             idle_odd;
  logic [FP_W-1:0]  digit_pos;
  logic             send_armed;
  logic [7:0]       msg_id;
  logic [7:0]       payload [MAX_PAYLOAD];
  logic [CNT_W-1:0] payload_len;
  logic [7:0]       digit_sum;

  initial begin
    fail_count_o  = 0;
    samples_due_o = 0;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (fail_count_o < 40)
      $display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic logic [11:0] dac_level(input logic [1:0] sym, input int i);
    int          j;
    logic [10:0] arc;
    j   = (i + (sym[0] ? 16 : 0)) % 32;
    arc = sym[1] ? HALF_ARC[j % 16] : FULL_ARC[j % 16];
    return (j < 16) ? MIDSCALE + arc : MIDSCALE - arc;
  endfunction

  // digit p of the current frame, least significant digit of each field first
  function automatic logic [1:0] frame_digit(input int p);
    int data_end;
    int len;
    data_end = 8 + 4 * payload_len;
    len      = payload_len;
    if (p == 0) return SYNC_DIG_A;
    if (p == 1) return SYNC_DIG_B;
    if (p < 4) return msg_id[2*(p-2) +: 2];
    if (p < 8) return 2'((len >> (2 * (p - 4))) & 3);
    if (p < data_end) return payload[(p-8)/4][2*((p-8)%4) +: 2];
    return digit_sum[2*((p-data_end)%4) +: 2];
  endfunction

  task automatic take_request(input logic [1:0] act, input logic [7:0] b);
    logic      busy;
    logic [1:0] sym;
    logic      frame_flag;
    int        data_end;
    dac_beat_t beat;
    busy = send_armed || in_frame;
    case (act)
      ACT_WRITE: begin
        if (!busy && payload_len < MAX_PAYLOAD) begin
          payload[payload_len] = b;
          payload_len++;
        end
      end
      ACT_SEND: begin
        if (!busy) begin
          msg_id++;
          send_armed = 1'b1;
        end
      end
      ACT_BUFFER: begin
        if (in_frame) begin
          data_end   = 8 + 4 * payload_len;
          frame_flag = 1'b1;
          sym        = frame_digit(digit_pos);
          if (digit_pos < data_end) digit_sum += 8'(sym);
          if (digit_pos + 1 < data_end + 4) begin
            digit_pos++;
          end else begin
            digit_pos   = '0;
            in_frame    = 1'b0;
            payload_len = '0;
          end
        end else begin
          frame_flag = 1'b0;
          sym        = idle_odd ? SYM_IDLE_B : SYM_IDLE_A;
          if (!idle_odd) begin
            idle_odd = 1'b1;
          end else begin
            // a pending send starts right after the second idle symbol
            idle_odd = 1'b0;
            if (send_armed) begin
              send_armed = 1'b0;
              in_frame   = 1'b1;
              digit_pos  = '0;
              digit_sum  = '0;
            end
          end
        end
        for (int i = 0; i < SAMPLES_PER_SYMBOL; i++) begin
          beat.level    = dac_level(sym, i);
          beat.last     = (i == SAMPLES_PER_SYMBOL - 1);
          beat.sym      = sym;
          beat.in_frame = frame_flag;
          expected_beats.push_back(beat);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    dac_beat_t want;
    if (!rst_ni) begin
      in_frame    = 1'b0;
      idle_odd    = 1'b0;
      digit_pos   = '0;
      send_armed  = 1'b0;
      msg_id      = '0;
      payload_len = '0;
      digit_sum   = '0;
      expected_beats.delete();
    end else begin
      // output beat first: a request taken on the same edge queues behind it
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata_i, 16'h0);
        end else begin
          want = expected_beats.pop_front();
          if (m_axis_tdata_i !== {4'h0, want.level})
            report_mismatch("dac_sample", m_axis_tdata_i, {4'h0, want.level});
          if (m_axis_tlast_i !== want.last)
            report_mismatch("last_sample", 16'(m_axis_tlast_i), 16'(want.last));
          if (m_axis_tuser_i[1:0] !== want.sym)
            report_mismatch("symbol", 16'(m_axis_tuser_i[1:0]), 16'(want.sym));
          if (m_axis_tuser_i[2] !== want.in_frame)
            report_mismatch("sending", 16'(m_axis_tuser_i[2]), 16'(want.in_frame));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        take_request(s_axis_tuser_i, s_axis_tdata_i);
    end
    samples_due_o = expected_beats.size();
  end

endmodule

// ----- verif/testbench.sv -----
module testbench;
  import ffsm_pkg::*;

  // action code the block has no use for; it must be taken and ignored
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // slowest run: up to two hundred symbols, 32 beats each, every beat behind a
  // random sink stall, plus long source gaps; taken many times
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 100;
  localparam int DRAIN_CYCLES = 64;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [7:0]  s_data;
  logic [1:0]  s_user;
  logic        m_valid;
  logic        m_ready;
  logic [15:0] m_data;
  logic        m_last;
  logic [2:0]  m_user;

  logic steady;        // both sides stop idling while set
  int   cycles;
  int   fail_count;
  int   samples_due;
  int   symbols_asked;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  framed_four_symbol_modulator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  ffsm_sample_checker checker_0 (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tlast_i  (m_last),
    .m_axis_tuser_i  (m_user),
    .fail_count_o    (fail_count),
    .samples_due_o   (samples_due)
  );

  // watchdog: a hang or a lost sample ends here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // sample sink: stalls about a third of the time unless steady
  always @(negedge clk_i) begin
    if (rst_ni) m_ready <= steady || ($urandom_range(0, 99) >= 32);
  end

  // source gap before a beat; mostly short, sometimes long enough to land
  // anywhere inside a 32-beat symbol
  task automatic source_gap();
    int n;
    if (!steady && $urandom_range(0, 99) < 32) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 3);
      s_valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // one input beat, held until taken; returns at the following falling edge
  task automatic put_beat(input logic [1:0] act, input logic [7:0] b);
    source_gap();
    s_valid <= 1'b1;
    s_user  <= act;
    s_data  <= b;
    do @(posedge clk_i); while (!s_ready);
    @(negedge clk_i);
    if (act == ACT_BUFFER) symbols_asked++;
  endtask

  // load k bytes, ask for a frame, then request enough symbols to cover the
  // idle pair (plus one for alignment), the frame and a little idle after it;
  // with noise, stray writes and sends land while the frame is busy
  task automatic frame_run(input int k, input bit noise);
    int  n;
    logic [7:0] b;
    for (int j = 0; j < k; j++) begin
      b = 8'($urandom_range(0, 255));
      if (k > MAX_PAYLOAD && j == 0) b = 8'h00;
      if (k > MAX_PAYLOAD && j == 1) b = 8'hFF;
      put_beat(ACT_WRITE, b);
    end
    put_beat(ACT_SEND, 8'($urandom_range(0, 255)));
    n = 3 + 12 + 4 * ((k > MAX_PAYLOAD) ? MAX_PAYLOAD : k) + $urandom_range(0, 2);
    repeat (n) begin
      if (noise && $urandom_range(0, 99) < 15) begin
        if ($urandom_range(0, 1) == 1)
          put_beat(ACT_WRITE, 8'($urandom_range(0, 255)));
        else
          put_beat(ACT_SEND, 8'($urandom_range(0, 255)));
      end
      put_beat(ACT_BUFFER, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int k;
    int run_idx;
    rst_ni        = 1'b0;
    s_valid       = 1'b0;
    s_data        = '0;
    s_user        = ACT_BUFFER;
    m_ready       = 1'b0;
    steady        = 1'b0;
    symbols_asked = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: unused code, idle pair, empty frame with a dropped second
    // send and a dropped write while the send is pending
    put_beat(ACT_UNUSED, 8'h5A);
    put_beat(ACT_BUFFER, 8'h00);
    put_beat(ACT_BUFFER, 8'hFF);
    put_beat(ACT_SEND, 8'h00);
    put_beat(ACT_SEND, 8'hFF);
    put_beat(ACT_WRITE, 8'hFF);
    repeat (14) put_beat(ACT_BUFFER, 8'h00);

    // random: mostly well-formed frames with random content; the second run
    // overfills the payload, the first runs with no idling on either side
    symbols_asked = 0;
    run_idx       = 0;
    while (symbols_asked < RANDOM_ITEMS) begin
      if (run_idx == 1)
        k = MAX_PAYLOAD + 1;
      else if ($urandom_range(0, 9) == 0)
        k = MAX_PAYLOAD;
      else
        k = $urandom_range(0, 4);
      steady = (run_idx == 0);
      frame_run(k, run_idx != 0);
      run_idx++;
    end
    steady  = 1'b0;
    s_valid <= 1'b0;

    // drain, then give a stray beat time to show up
    while (samples_due != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
